// ===== design/assert_macros.svh =====
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/scpa_pkg.sv =====
// shared types, codes and default sizes of the size class pool allocator
package scpa_pkg;

  // default geometry; granule and arena sizes are powers of two
  localparam int unsigned GRANULE_BYTES_DEF     = 16;
  localparam int unsigned NUM_ARENAS_DEF        = 8;
  localparam int unsigned ARENA_BYTES_DEF       = 4096;
  localparam int unsigned LARGE_BLOCK_BYTES_DEF = 1024;

  // one request word carries a size in 4-byte units
  localparam int unsigned WORD_SHIFT = 2;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned STAT_W = 2;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EXHAUSTED = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_IGNORED   = 2'd3;

  // request opcodes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // decoded request kind, latched between decode and commit
  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_POP,
    KIND_CARVE,
    KIND_FULL,
    KIND_FREE,
    KIND_IGNORE
  } kind_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic decode;
    logic commit;
  } scpa_cmd_t;

endpackage

// ===== design/size_class_pool_allocator.sv =====
// top level of the size class pool allocator
//
// segregated free-list allocator: an allocate word gives a size in 4-byte
// units, rounded up to whole granules; one granule less than the count picks
// the class, and sizes past the second-to-last class share the large-block
// class. each class owns one arena starting at base_address plus class times
// ARENA_BYTES. an allocate pops the class free list, else carves the next
// unused block, else reports the arena exhausted (status 2); a zero or too
// large size gives status 1. a free locates the arena from the address and
// pushes the granule onto that class's list; address zero or an address
// outside the pool gives status 3. every request word yields one result word.
// each accepted word passes through decode (with the link memory read), then
// commit of class state and the result register, and a new word is taken in
// the commit cycle while results are taken; the separate decode step comes
// from the registered read of the link memory ahead of the list-head update.
// the link memory needs no clearing pass after reset. base_address must be
// written only while idle; the block itself does not enforce it.
// GRANULE_BYTES and ARENA_BYTES must be powers of two and LARGE_BLOCK_BYTES
// a multiple of the granule.

module size_class_pool_allocator #(
  parameter int unsigned GRANULE_BYTES     = scpa_pkg::GRANULE_BYTES_DEF,
  parameter int unsigned NUM_ARENAS        = scpa_pkg::NUM_ARENAS_DEF,
  parameter int unsigned ARENA_BYTES       = scpa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned LARGE_BLOCK_BYTES = scpa_pkg::LARGE_BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: base address of arena zero
  input  logic                        cfg_we,
  input  logic [scpa_pkg::ADDR_W-1:0] cfg_wdata,
  // request words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [scpa_pkg::SIZE_W-1:0] size_words,
  input  logic [scpa_pkg::ADDR_W-1:0] block_address,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scpa_pkg::ADDR_W-1:0] granted_address,
  output logic [scpa_pkg::STAT_W-1:0] status
);
  import scpa_pkg::*;

  scpa_cmd_t cmd;

  // sequencing and handshake
  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // size decode, class state, link memory and result register
  scpa_datapath #(
    .GRANULE_BYTES     (GRANULE_BYTES),
    .NUM_ARENAS        (NUM_ARENAS),
    .ARENA_BYTES       (ARENA_BYTES),
    .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .func            (func),
    .size_words      (size_words),
    .block_address   (block_address),
    .granted_address (granted_address),
    .status          (status)
  );

endmodule

// ===== design/scpa_ctrl.sv =====
// controller state machine of the size class pool allocator
`include "assert_macros.svh"

module scpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output scpa_pkg::scpa_cmd_t cmd
);
  import scpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) || ((state == S_EXEC) && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.load_in = accept;
    cmd.decode  = (state == S_DECODE);
    cmd.commit  = (state == S_EXEC) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = accept ? S_DECODE : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_HOLDS(a_commit_into_free_slot, clk, rst, cmd.commit |-> out_free, "commit over a held result")
  `ASSERT_HOLDS(a_no_accept_in_decode, clk, rst, (state == S_DECODE) |-> in_stall, "word taken during decode")
  `ASSERT_HOLDS(a_commit_shows_result, clk, rst, cmd.commit |=> out_valid, "committed result not shown")

endmodule

// ===== design/scpa_datapath.sv =====
// datapath of the size class pool allocator: decode, class state and link memory
`include "assert_macros.svh"

module scpa_datapath #(
  parameter int unsigned GRANULE_BYTES     = scpa_pkg::GRANULE_BYTES_DEF,
  parameter int unsigned NUM_ARENAS        = scpa_pkg::NUM_ARENAS_DEF,
  parameter int unsigned ARENA_BYTES       = scpa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned LARGE_BLOCK_BYTES = scpa_pkg::LARGE_BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scpa_pkg::ADDR_W-1:0] cfg_wdata,
  input  scpa_pkg::scpa_cmd_t         cmd,
  input  logic                        func,
  input  logic [scpa_pkg::SIZE_W-1:0] size_words,
  input  logic [scpa_pkg::ADDR_W-1:0] block_address,
  output logic [scpa_pkg::ADDR_W-1:0] granted_address,
  output logic [scpa_pkg::STAT_W-1:0] status
);
  import scpa_pkg::*;

  localparam int unsigned GS         = $clog2(GRANULE_BYTES);
  localparam int unsigned AS         = $clog2(ARENA_BYTES);
  localparam int unsigned POOL_G     = NUM_ARENAS * ARENA_BYTES / GRANULE_BYTES;
  localparam int unsigned POOL_BYTES = NUM_ARENAS * ARENA_BYTES;
  localparam int unsigned IDX_W      = (POOL_G > 1) ? $clog2(POOL_G) : 1;
  localparam int unsigned CLS_W      = $clog2(NUM_ARENAS);
  localparam int unsigned CNT_W      = $clog2(ARENA_BYTES / GRANULE_BYTES + 1);
  localparam int unsigned UNIT_W     = $clog2(LARGE_BLOCK_BYTES / GRANULE_BYTES + 1);
  localparam int unsigned BYTES_W    = SIZE_W + WORD_SHIFT;
  localparam int unsigned GRAN_W     = BYTES_W + 1;
  localparam int unsigned LARGE_G    = LARGE_BLOCK_BYTES / GRANULE_BYTES;

  // request registers
  logic              req_func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] base_address;

  // per-class state
  logic             head_valid [NUM_ARENAS];
  logic [IDX_W-1:0] head_idx   [NUM_ARENAS];
  logic [CNT_W-1:0] carve      [NUM_ARENAS];
  logic [CNT_W-1:0] cap_tab    [NUM_ARENAS];

  // link memory: valid bit over granule index
  logic [IDX_W:0] link_mem [POOL_G];
  logic [IDX_W:0] link_rd;

  // decode results
  kind_t            kind;
  logic [CLS_W-1:0] cls;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] carve_off;

  // decode logic
  logic [BYTES_W-1:0]      bytes;
  logic [GRAN_W-1:0]       granules;
  logic                    bad_size;
  logic                    is_large;
  logic [CLS_W-1:0]        cls_alloc;
  logic [UNIT_W-1:0]       units;
  logic [UNIT_W+CNT_W-1:0] prod;
  logic [ADDR_W-1:0]       off;
  logic                    outside;
  logic [CLS_W-1:0]        cls_d;
  kind_t                   kind_d;
  logic [ADDR_W-1:0]       pop_addr;
  logic [ADDR_W-1:0]       carve_addr;

  // blocks per arena for each class
  for (genvar c = 0; c < NUM_ARENAS; c++) begin : g_cap
    localparam int unsigned CLASS_BYTES =
      (c < NUM_ARENAS - 1) ? (c + 1) * GRANULE_BYTES : LARGE_BLOCK_BYTES;
    localparam int unsigned CAP = ARENA_BYTES / CLASS_BYTES;
    assign cap_tab[c] = CNT_W'(CAP);
  end

  always_comb begin
    bytes     = {req_size, {WORD_SHIFT{1'b0}}};
    granules  = GRAN_W'((GRAN_W'(bytes) + GRAN_W'(GRANULE_BYTES - 1)) >> GS);
    bad_size  = (req_size == '0) || (ADDR_W'(bytes) > ADDR_W'(LARGE_BLOCK_BYTES));
    is_large  = (granules >= GRAN_W'(NUM_ARENAS));
    cls_alloc = is_large ? CLS_W'(NUM_ARENAS - 1) : CLS_W'(granules - 1'b1);
    units     = is_large ? UNIT_W'(LARGE_G) : UNIT_W'(granules);

    off       = req_addr - base_address;
    outside   = (off >= ADDR_W'(POOL_BYTES));

    if (req_func == FUNC_FREE) begin
      cls_d = outside ? '0 : off[AS +: CLS_W];
    end else begin
      cls_d = bad_size ? '0 : cls_alloc;
    end

    prod = units * carve[cls_d];

    if (req_func == FUNC_FREE) begin
      kind_d = ((req_addr == '0) || outside) ? KIND_IGNORE : KIND_FREE;
    end else if (bad_size) begin
      kind_d = KIND_BAD;
    end else if (head_valid[cls_d]) begin
      kind_d = KIND_POP;
    end else if (carve[cls_d] == cap_tab[cls_d]) begin
      kind_d = KIND_FULL;
    end else begin
      kind_d = KIND_CARVE;
    end
  end

  assign pop_addr   = base_address + (ADDR_W'(head_idx[cls]) << GS);
  assign carve_addr = base_address + (ADDR_W'(cls) << AS) + (ADDR_W'(carve_off) << GS);

  // configuration and class control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      for (int i = 0; i < NUM_ARENAS; i++) begin
        head_valid[i] <= 1'b0;
        carve[i]      <= '0;
      end
    end else begin
      if (cfg_we) base_address <= cfg_wdata;
      if (cmd.commit) begin
        case (kind)
          KIND_POP: begin
            head_valid[cls] <= link_rd[IDX_W];
          end
          KIND_CARVE: begin
            carve[cls] <= carve[cls] + 1'b1;
          end
          KIND_FREE: begin
            head_valid[cls] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers and link memory
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_func <= func;
      req_size <= size_words;
      req_addr <= block_address;
    end
    if (cmd.decode) begin
      kind      <= kind_d;
      cls       <= cls_d;
      free_idx  <= off[GS +: IDX_W];
      carve_off <= prod[CNT_W-1:0];
      link_rd   <= link_mem[head_idx[cls_d]];
    end
    if (cmd.commit) begin
      case (kind)
        KIND_POP: begin
          head_idx[cls]   <= link_rd[IDX_W-1:0];
          granted_address <= pop_addr;
          status          <= STATUS_DONE;
        end
        KIND_CARVE: begin
          granted_address <= carve_addr;
          status          <= STATUS_DONE;
        end
        KIND_FREE: begin
          link_mem[free_idx] <= {head_valid[cls], head_idx[cls]};
          head_idx[cls]      <= free_idx;
          granted_address    <= '0;
          status             <= STATUS_DONE;
        end
        KIND_FULL: begin
          granted_address <= '0;
          status          <= STATUS_EXHAUSTED;
        end
        KIND_BAD: begin
          granted_address <= '0;
          status          <= STATUS_BAD_SIZE;
        end
        default: begin
          granted_address <= '0;
          status          <= STATUS_IGNORED;
        end
      endcase
    end
  end

  `ASSERT_HOLDS(a_pop_needs_head, clk, rst, (cmd.commit && (kind == KIND_POP)) |-> head_valid[cls], "pop from an empty free list")
  `ASSERT_HOLDS(a_carve_below_cap, clk, rst, (cmd.commit && (kind == KIND_CARVE)) |-> (carve[cls] != cap_tab[cls]), "carve past arena capacity")
  `ASSERT_HOLDS(a_free_sets_head, clk, rst, (cmd.commit && (kind == KIND_FREE)) |=> head_valid[$past(cls)], "free left list head empty")

endmodule

// ===== tb/size_class_pool_allocator_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the size class pool allocator, directed table then random traffic
module size_class_pool_allocator_tb;
  import scpa_pkg::*;

  // geometry the block is built with
  localparam int unsigned GRAN          = GRANULE_BYTES_DEF;
  localparam int unsigned NUM_CLASSES   = NUM_ARENAS_DEF;
  localparam int unsigned ARENA         = ARENA_BYTES_DEF;
  localparam int unsigned LARGE         = LARGE_BLOCK_BYTES_DEF;
  localparam int unsigned POOL_BYTES    = NUM_CLASSES * ARENA;
  localparam int unsigned POOL_GRANULES = POOL_BYTES / GRAN;
  localparam int unsigned IDX_W         = $clog2(POOL_GRANULES);
  localparam int unsigned CARVE_W       = $clog2(ARENA / GRAN) + 1;
  localparam int unsigned RANDOM_PER_PHASE = 320;
  localparam int unsigned NUM_PHASES    = 5;
  localparam int unsigned LONG_HOLD     = 300;

  // one result word as the block gives it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] st;
  } grant_t;

  // result typed in by hand for a directed row, when on is set
  typedef struct packed {
    bit     on;
    grant_t val;
  } pin_t;

  // one row of the directed table
  typedef struct packed {
    logic              fn;
    logic [SIZE_W-1:0] words;
    logic [ADDR_W-1:0] ba;
    pin_t              pin;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = FUNC_ALLOC;
  logic [SIZE_W-1:0] size_words = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [STAT_W-1:0] status;

  size_class_pool_allocator uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .size_words      (size_words),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .granted_address (granted_address),
    .status          (status)
  );

  always #2 clk = ~clk;

  // shadow copy of the allocator state
  logic [ADDR_W-1:0]  pool_base = '0;
  bit                 head_ok  [NUM_CLASSES];
  logic [IDX_W-1:0]   head_idx [NUM_CLASSES];
  logic [CARVE_W-1:0] carved   [NUM_CLASSES];
  bit                 link_ok  [POOL_GRANULES];
  logic [IDX_W-1:0]   link_idx [POOL_GRANULES];

  grant_t            grants_due[$];   // results owed by the block, oldest first
  pin_t              pins_due[$];     // one per offered word, hand-typed result or none
  logic [ADDR_W-1:0] live_blocks[$];  // blocks handed out and not yet given back

  int unsigned fails = 0;
  int          stall_left = 0;
  bit          hold_off_req = 1'b0;
  bit          quiet_mode = 1'b0;

  // pinned results read straight off the spec with the base at zero
  dir_row_t directed_rows [0:24] = '{
    // bad sizes: zero, largest field value, one word past the large block
    {FUNC_ALLOC, 16'd0,     32'h0,        1'b1, 32'h0,    STATUS_BAD_SIZE},
    {FUNC_ALLOC, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0,   STATUS_BAD_SIZE},
    {FUNC_ALLOC, 16'd257,   32'h0,        1'b1, 32'h0,    STATUS_BAD_SIZE},
    // zero base: first class 0 block sits at address zero
    {FUNC_ALLOC, 16'd1,     32'h0,        1'b1, 32'h0,    STATUS_DONE},
    // null free, then frees beyond the pool
    {FUNC_FREE,  16'hFFFF,  32'h0,        1'b1, 32'h0,    STATUS_IGNORED},
    {FUNC_FREE,  16'd0,     32'hFFFF_FFFF, 1'b1, 32'h0,   STATUS_IGNORED},
    {FUNC_FREE,  16'd0,     32'h0000_8000, 1'b1, 32'h0,   STATUS_IGNORED},
    // carving from several arenas
    {FUNC_ALLOC, 16'd256,   32'h0,        1'b1, 32'h7000, STATUS_DONE},
    {FUNC_ALLOC, 16'd4,     32'h0,        1'b1, 32'h0010, STATUS_DONE},
    {FUNC_ALLOC, 16'd5,     32'h0,        1'b1, 32'h1000, STATUS_DONE},
    {FUNC_ALLOC, 16'd28,    32'h0,        1'b1, 32'h6000, STATUS_DONE},
    {FUNC_ALLOC, 16'd29,    32'h0,        1'b1, 32'h7400, STATUS_DONE},
    {FUNC_ALLOC, 16'd256,   32'h0,        1'b1, 32'h7800, STATUS_DONE},
    {FUNC_ALLOC, 16'd200,   32'h0,        1'b1, 32'h7C00, STATUS_DONE},
    // large arena now full
    {FUNC_ALLOC, 16'd100,   32'h0,        1'b1, 32'h0,    STATUS_EXHAUSTED},
    // unaligned free, popped back as its granule
    {FUNC_FREE,  16'd0,     32'h7404,     1'b0, 32'h0,    STATUS_DONE},
    {FUNC_ALLOC, 16'd256,   32'h0,        1'b0, 32'h0,    STATUS_DONE},
    // double free hands the same block out twice
    {FUNC_FREE,  16'd0,     32'h0010,     1'b0, 32'h0,    STATUS_DONE},
    {FUNC_FREE,  16'd0,     32'h0010,     1'b0, 32'h0,    STATUS_DONE},
    {FUNC_ALLOC, 16'd3,     32'h0,        1'b0, 32'h0,    STATUS_DONE},
    {FUNC_ALLOC, 16'd3,     32'h0,        1'b0, 32'h0,    STATUS_DONE},
    {FUNC_FREE,  16'd0,     32'h1000,     1'b0, 32'h0,    STATUS_DONE},
    {FUNC_ALLOC, 16'd8,     32'h0,        1'b0, 32'h0,    STATUS_DONE},
    // last byte of the pool, unaligned
    {FUNC_FREE,  16'd0,     32'h7FFF,     1'b0, 32'h0,    STATUS_DONE},
    {FUNC_ALLOC, 16'd64,    32'h0,        1'b0, 32'h0,    STATUS_DONE}
  };

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_ok[c]  = 1'b0;
      head_idx[c] = '0;
      carved[c]   = '0;
    end
    for (int g = 0; g < POOL_GRANULES; g++) begin
      link_ok[g]  = 1'b0;
      link_idx[g] = '0;
    end
  end

  // works out the result word of one request and moves the shadow state on
  function automatic grant_t predict_grant(input logic fn, input logic [SIZE_W-1:0] words,
                                           input logic [ADDR_W-1:0] ba);
    grant_t            r;
    logic [ADDR_W-1:0] bytes, sz, off;
    int unsigned       cls;
    logic [IDX_W-1:0]  idx;
    r = '{addr: '0, st: STATUS_DONE};
    if (fn == FUNC_ALLOC) begin
      bytes = {14'd0, words, 2'b00};
      sz = ((bytes + GRAN - 1) / GRAN) * GRAN;
      if (sz == 0 || sz > LARGE) begin
        r.st = STATUS_BAD_SIZE;
      end else begin
        cls = sz / GRAN - 1;
        // everything past the second-to-last class shares the large blocks
        if (cls >= NUM_CLASSES - 1) begin
          sz  = LARGE;
          cls = NUM_CLASSES - 1;
        end
        if (head_ok[cls]) begin
          idx           = head_idx[cls];
          r.addr        = pool_base + idx * GRAN;
          head_ok[cls]  = link_ok[idx];
          head_idx[cls] = link_idx[idx];
        end else if (carved[cls] != ARENA / sz) begin
          r.addr      = pool_base + cls * ARENA + sz * carved[cls];
          carved[cls] = carved[cls] + 1'b1;
        end else begin
          r.st = STATUS_EXHAUSTED;
        end
      end
    end else if (ba == 0) begin
      r.st = STATUS_IGNORED;
    end else begin
      off = ba - pool_base;   // wraps modulo 2^32
      cls = off / ARENA;
      if (cls >= NUM_CLASSES) begin
        r.st = STATUS_IGNORED;
      end else begin
        // address rounded down to its granule
        idx           = IDX_W'(off / GRAN);
        link_ok[idx]  = head_ok[cls];
        link_idx[idx] = head_idx[cls];
        head_ok[cls]  = 1'b1;
        head_idx[cls] = idx;
      end
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watch both handshakes at the rising edge
  always @(posedge clk) begin : watch_ports
    grant_t pred, seen, want;
    pin_t   pin;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = predict_grant(func, size_words, block_address);
        pin  = pins_due.pop_front();
        grants_due.push_back(pin.on ? pin.val : pred);
        if (func == FUNC_ALLOC && pred.st == STATUS_DONE) live_blocks.push_back(pred.addr);
      end
      if (out_valid && !out_stall) begin
        seen = '{addr: granted_address, st: status};
        if (grants_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word: addr %h status %0d", seen.addr, seen.st);
        end else begin
          want = grants_due.pop_front();
          if (seen.addr !== want.addr || seen.st !== want.st) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: addr %h status %0d, expected addr %h status %0d",
                       seen.addr, seen.st, want.addr, want.st);
          end
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and the odd long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 99) < 30) begin
        stall_left = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // present one request word and hold it until it is taken
  task automatic offer_word(input logic fn, input logic [SIZE_W-1:0] words,
                            input logic [ADDR_W-1:0] ba, input pin_t pin);
    int gap;
    gap = (!quiet_mode && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pins_due.push_back(pin);
    in_valid      <= 1'b1;
    func          <= fn;
    size_words    <= words;
    block_address <= ba;
    do @(posedge clk); while (in_stall);
  endtask

  // one random request: mostly sensible alloc and free traffic, some noise
  task automatic random_word();
    int                r, k;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r >= 50 && r < 90 && live_blocks.size() == 0) r = 0;
    if (r < 50) begin
      // well-formed allocate, biased towards the small large-block arena
      w = ($urandom_range(0, 9) < 4) ? SIZE_W'($urandom_range(29, 256))
                                     : SIZE_W'($urandom_range(1, 28));
      offer_word(FUNC_ALLOC, w, $urandom, '0);
    end else if (r < 90) begin
      // give back a live block, sometimes unaligned, sometimes twice
      k = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[k];
      if (r < 85) live_blocks.delete(k);
      if ($urandom_range(0, 3) == 0) a = a + $urandom_range(1, GRAN - 1);
      offer_word(FUNC_FREE, SIZE_W'($urandom), a, '0);
    end else if (r < 95) begin
      // sizes across the whole field, mostly too large
      w = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom);
      offer_word(FUNC_ALLOC, w, $urandom, '0);
    end else begin
      // null, wild, foreign and just-past-the-pool frees
      case ($urandom_range(0, 3))
        0:       a = '0;
        1:       a = $urandom;
        2:       a = pool_base + $urandom_range(0, POOL_BYTES - 1);
        default: a = pool_base + POOL_BYTES + $urandom_range(0, 255);
      endcase
      offer_word(FUNC_FREE, SIZE_W'($urandom), a, '0);
    end
  endtask

  // stop sending and let every owed result word arrive
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // new base while idle; live blocks keep their place in the pool
  task automatic write_base(input logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    foreach (live_blocks[j]) live_blocks[j] = live_blocks[j] - pool_base + v;
    pool_base = v;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] phase_base [NUM_PHASES];
    phase_base[0] = '0;
    phase_base[1] = 32'hFFFF_FFF0;            // top granule, arenas wrap past zero
    phase_base[2] = $urandom | 32'h1;        // base off the granule grid
    phase_base[3] = 32'h8000_0000;
    phase_base[4] = '0;                      // written back to the low extreme
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].fn, directed_rows[i].words, directed_rows[i].ba,
                 directed_rows[i].pin);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_base(phase_base[p]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        quiet_mode = ((i / 64) % 4) == 3;
        if (i == 100) hold_off_req = 1'b1;   // receiver backs off, input fills up
        random_word();
      end
    end

    drain();
    // catch any stray result word after the last expected one
    repeat (20) @(posedge clk);
    if (fails == 0 && grants_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
